[rtl/snpu_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and a saturation helper for the spiking neuron population update.
// It depends on nothing. The top level and the testbench import it.
package snpu_pkg;

	// Population size and the width of a neuron index.
	localparam int NEURONS = 1024;
	localparam int IDX_W   = $clog2(NEURONS);

	// Register file layout of the configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_POTENTIAL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_JUMP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_POTENTIAL  = 3'd5;

	// Register values after reset.
	localparam logic        [16:0] RST_STEP_SIZE       = 17'd32768;
	localparam logic        [16:0] RST_RECOVERY_RATE   = 17'd1311;
	localparam logic signed [17:0] RST_RECOVERY_GAIN   = 18'sd13107;
	localparam logic signed [23:0] RST_RESET_POTENTIAL = -24'sd4259840;
	localparam logic signed [23:0] RST_RECOVERY_JUMP   = 24'sd524288;
	localparam logic signed [23:0] RST_PEAK_POTENTIAL  = 24'sd1966080;

	// Commands carried by an item.
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_RESET = 1'b1;

	// Q16.16 constants of the Izhikevich equations; K_70 is a plain integer.
	localparam logic signed [13:0] K_POINT04 = 14'sd2621;
	localparam logic signed [31:0] K_140     = 32'sd9175040;
	localparam logic signed [31:0] K_MINUS70 = -32'sd4587520;
	localparam logic signed [31:0] K_70      = 32'sd70;

	typedef struct packed {
		logic                    cmd;
		logic [IDX_W-1:0]        neuron_index;
		logic signed [31:0]      current;
	} snpu_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]        neuron_out;
		logic signed [31:0]      new_potential;
		logic signed [31:0]      new_recovery;
		logic                    spike;
	} snpu_out_t;

	// Saturate a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		if (x > 48'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (x < -48'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return signed'(x[31:0]);
		end
	endfunction

endpackage

[rtl/spiking_neuron_population_update.sv]
`timescale 1ns / 1ps
// Top level of the spiking neuron population update: Izhikevich neurons, one Euler step per item.
// Depends on snpu_pkg and on snpu_ram, which holds v and u of every neuron.
//
//   channel   ports                              direction  handshake
//   --------  ---------------------------------  ---------  -------------------------------
//   command   start, busy, request (snpu_in_t)   in         taken when start & !busy
//   result    done, result (snpu_out_t)          out        one cycle strobe, never held off
//   config    cfg_write, cfg_index, cfg_data     in         written when cfg_write is high
//
// An item may be taken in every cycle in which busy is low. Its result passes the registered
// state RAM read and six register stages and shows on the result port, one result per item,
// in order of arrival. The stages split the Euler step so that no path holds more than one
// multiplication; the last stage picks between step, spike and reset. busy rises while an
// item for the same neuron is still in flight, so items for one neuron wait until the previous
// one is written back to the state RAM; a sweep over distinct neurons runs at full rate. Reset
// clears the valid bits and loads the default register values; the state RAM is not cleared,
// so the user must see that a neuron is stepped only after its reset item; the block does not
// enforce this. The result side has no stall, so the pipeline always advances.
module spiking_neuron_population_update
	import snpu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  snpu_in_t              request,
	output logic                  done,
	output snpu_out_t             result,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic        [16:0] dt_q;
	logic        [16:0] a_q;
	logic signed [17:0] b_q;
	logic signed [23:0] c_q;
	logic signed [23:0] d_q;
	logic signed [23:0] peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= RST_STEP_SIZE;
			a_q    <= RST_RECOVERY_RATE;
			b_q    <= RST_RECOVERY_GAIN;
			c_q    <= RST_RESET_POTENTIAL;
			d_q    <= RST_RECOVERY_JUMP;
			peak_q <= RST_PEAK_POTENTIAL;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STEP_SIZE:       dt_q   <= cfg_data[16:0];
				REG_RECOVERY_RATE:   a_q    <= cfg_data[16:0];
				REG_RECOVERY_GAIN:   b_q    <= signed'(cfg_data[17:0]);
				REG_RESET_POTENTIAL: c_q    <= signed'(cfg_data);
				REG_RECOVERY_JUMP:   d_q    <= signed'(cfg_data);
				REG_PEAK_POTENTIAL:  peak_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// The unsigned registers take part in signed products with a zero sign bit.
	logic signed [17:0] dt_sx;
	logic signed [17:0] a_sx;
	logic signed [31:0] peak_ext;

	assign dt_sx    = signed'({1'b0, dt_q});
	assign a_sx     = signed'({1'b0, a_q});
	assign peak_ext = 32'(peak_q);

	// Pipeline registers, one group per stage.
	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic                     valid_s7;
	logic                     cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6;
	logic [IDX_W-1:0]         idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic signed [31:0]       cur_s1, cur_s2, cur_s3;
	logic signed [31:0]       v_s2, v_s3, v_s4, v_s5;
	logic signed [31:0]       u_s2, u_s3, u_s4, u_s5, u_s6;
	logic                     spk_s2, spk_s3, spk_s4, spk_s5, spk_s6;
	logic signed [63:0]       vv_s2;
	logic signed [49:0]       bv_s2;
	logic signed [59:0]       vsqk_s3;
	logic signed [34:0]       diff_s3;
	logic signed [31:0]       vdot_s4;
	logic signed [52:0]       adiff_s4;
	logic signed [49:0]       dtv_s5;
	logic signed [31:0]       udot_s5;
	logic signed [31:0]       vn_s6;
	logic signed [49:0]       dtu_s6;
	snpu_out_t                result_s7;

	// An item must not read a neuron whose update is still on its way to the RAM.
	logic hazard;
	logic accept;

	assign hazard = (valid_s1 && idx_s1 == request.neuron_index)
		|| (valid_s2 && idx_s2 == request.neuron_index)
		|| (valid_s3 && idx_s3 == request.neuron_index)
		|| (valid_s4 && idx_s4 == request.neuron_index)
		|| (valid_s5 && idx_s5 == request.neuron_index)
		|| (valid_s6 && idx_s6 == request.neuron_index)
		|| (valid_s7 && result_s7.neuron_out == request.neuron_index);
	assign busy   = hazard;
	assign accept = start && !hazard;

	// State RAM: v in the upper half of a word, u in the lower half.
	logic [63:0] rd_data;

	snpu_ram #(
		.WIDTH (64),
		.DEPTH (NEURONS)
	) u_state_ram (
		.clk   (clk),
		.we    (valid_s7),
		.waddr (result_s7.neuron_out),
		.wdata ({result_s7.new_potential, result_s7.new_recovery}),
		.raddr (request.neuron_index),
		.rdata (rd_data)
	);

	// Stage 1: the old state arrives from the RAM; square v and form b*v.
	logic signed [31:0] v_rd;
	logic signed [31:0] u_rd;
	logic signed [63:0] vv_p;
	logic signed [49:0] bv_p;

	assign v_rd = signed'(rd_data[63:32]);
	assign u_rd = signed'(rd_data[31:0]);
	assign vv_p = v_rd * v_rd;
	assign bv_p = b_q * v_rd;

	// Stage 2: scale v squared by 0.04 and form b*v - u.
	logic signed [59:0] vsqk_p;
	logic signed [34:0] diff_p;

	assign vsqk_p = signed'(vv_s2[63:16]) * K_POINT04;
	assign diff_p = 35'(signed'(bv_s2[49:16])) - 35'(u_s2);

	// Stage 3: sum the terms of v' and multiply a by (b*v - u).
	logic signed [45:0] v5;
	logic signed [45:0] vsum;
	logic signed [52:0] adiff_p;

	assign v5      = (46'(v_s3) <<< 2) + 46'(v_s3);
	assign vsum    = 46'(signed'(vsqk_s3[59:16])) + v5 + 46'(K_140) - 46'(u_s3)
		+ 46'(cur_s3);
	assign adiff_p = a_sx * diff_s3;

	// Stage 4: finish u' and multiply dt by v'.
	logic signed [31:0] udot_p;
	logic signed [49:0] dtv_p;

	assign udot_p = sat32(48'(signed'(adiff_s4[52:16])));
	assign dtv_p  = dt_sx * vdot_s4;

	// Stage 5: new v before the clamp, and dt times u'.
	logic signed [31:0] vn_p;
	logic signed [49:0] dtu_p;

	assign vn_p  = sat32(48'(v_s5) + 48'(signed'(dtv_s5[49:16])));
	assign dtu_p = dt_sx * udot_s5;

	// Stage 6: new u, the clamp, and the choice between step, spike and reset.
	logic signed [31:0] nu_step;
	logic signed [31:0] nv_step;
	logic signed [31:0] nu_spike;
	logic signed [31:0] nu_reset;
	snpu_out_t          res_p;

	assign nu_step  = sat32(48'(u_s6) + 48'(signed'(dtu_s6[49:16])));
	assign nv_step  = (vn_s6 >= peak_ext) ? peak_ext : vn_s6;
	assign nu_spike = sat32(48'(u_s6) + 48'(d_q));
	// b*(-70) needs no saturation: b is at most 2^17 in magnitude.
	assign nu_reset = -(32'(b_q) * K_70);

	always_comb begin
		res_p.neuron_out = idx_s6;
		if (cmd_s6 == CMD_RESET) begin
			res_p.new_potential = K_MINUS70;
			res_p.new_recovery  = nu_reset;
			res_p.spike         = 1'b0;
		end else if (spk_s6) begin
			res_p.new_potential = 32'(c_q);
			res_p.new_recovery  = nu_spike;
			res_p.spike         = 1'b1;
		end else begin
			res_p.new_potential = nv_step;
			res_p.new_recovery  = nu_step;
			res_p.spike         = 1'b0;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		cmd_s1   <= request.cmd;
		idx_s1   <= request.neuron_index;
		cur_s1   <= request.current;

		cmd_s2   <= cmd_s1;
		idx_s2   <= idx_s1;
		cur_s2   <= cur_s1;
		v_s2     <= v_rd;
		u_s2     <= u_rd;
		spk_s2   <= (v_rd >= peak_ext);
		vv_s2    <= vv_p;
		bv_s2    <= bv_p;

		cmd_s3   <= cmd_s2;
		idx_s3   <= idx_s2;
		cur_s3   <= cur_s2;
		v_s3     <= v_s2;
		u_s3     <= u_s2;
		spk_s3   <= spk_s2;
		vsqk_s3  <= vsqk_p;
		diff_s3  <= diff_p;

		cmd_s4   <= cmd_s3;
		idx_s4   <= idx_s3;
		v_s4     <= v_s3;
		u_s4     <= u_s3;
		spk_s4   <= spk_s3;
		vdot_s4  <= sat32(48'(vsum));
		adiff_s4 <= adiff_p;

		cmd_s5   <= cmd_s4;
		idx_s5   <= idx_s4;
		v_s5     <= v_s4;
		u_s5     <= u_s4;
		spk_s5   <= spk_s4;
		dtv_s5   <= dtv_p;
		udot_s5  <= udot_p;

		cmd_s6   <= cmd_s5;
		idx_s6   <= idx_s5;
		u_s6     <= u_s5;
		spk_s6   <= spk_s5;
		vn_s6    <= vn_p;
		dtu_s6   <= dtu_p;

		result_s7 <= res_p;
	end

	assign done   = valid_s7;
	assign result = result_s7;

endmodule

[rtl/snpu_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Self-contained; the read returns the old contents when it meets a write to the same address.
module snpu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[tb/spiking_neuron_population_update_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for spiking_neuron_population_update (Izhikevich Euler step per item).
// Depends on snpu_pkg for the item types and register indexes, and on the RTL of the block.
module spiking_neuron_population_update_tb;
	import snpu_pkg::*;

	// Q16.16 constants of the neuron equations, kept apart from the package on purpose so that
	// a wrong constant in the RTL cannot hide behind the same wrong constant here.
	localparam longint Q_POINT04 = 2621;
	localparam longint Q_140     = 140 * 65536;
	localparam longint Q_MINUS70 = -70 * 65536;
	localparam longint Q_MAX     = 64'sd2147483647;
	localparam longint Q_MIN     = -64'sd2147483648;
	localparam int     POOL      = 24;
	localparam int     DRAIN_CYCLES = 20;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	snpu_in_t              request = '0;
	logic                  done;
	snpu_out_t             result;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	spiking_neuron_population_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Items still to be offered, and the neuron states that the block owes us, oldest first.
	snpu_in_t  queued_requests[$];
	snpu_out_t owed_states[$];

	// Our own copy of the register file, already widened with the sign each register carries.
	longint dt_q      = RST_STEP_SIZE;
	longint rate_q    = RST_RECOVERY_RATE;
	longint gain_q    = RST_RECOVERY_GAIN;
	longint reset_v_q = RST_RESET_POTENTIAL;
	longint jump_q    = RST_RECOVERY_JUMP;
	longint peak_q    = RST_PEAK_POTENTIAL;

	// Our own copy of v and u of every neuron.
	int potential_model[NEURONS];
	int recovery_model[NEURONS];

	// Which neurons have had their reset item; only those may be stepped.
	bit          live[NEURONS];
	int unsigned live_ids[$];
	int unsigned pool[POOL];

	int gap_pct = 0;
	int mismatch_count = 0;

	function automatic longint sat_q(input longint x);
		if (x > Q_MAX) begin
			return Q_MAX;
		end else if (x < Q_MIN) begin
			return Q_MIN;
		end
		return x;
	endfunction

	// Works out the state a neuron reports for one item and keeps it for the next item.
	// Every product is formed exactly in 64 bits and floored by the arithmetic shift.
	function automatic snpu_out_t izh_update(input snpu_in_t it);
		snpu_out_t   r;
		int unsigned n;
		longint      v, u, cur, vsq, vdot, diff, udot, vn;
		n = it.neuron_index;
		r = '0;
		r.neuron_out = it.neuron_index;
		if (it.cmd == CMD_RESET) begin
			v = Q_MINUS70;
			u = sat_q((gain_q * v) >>> 16);
		end else begin
			v = potential_model[n];
			u = recovery_model[n];
			if (v >= peak_q) begin
				// The neuron fires: v drops to c and u takes its jump.
				v = reset_v_q;
				u = sat_q(u + jump_q);
				r.spike = 1'b1;
			end else begin
				cur  = $signed(it.current);
				vsq  = (v * v) >>> 16;
				vdot = sat_q(((vsq * Q_POINT04) >>> 16) + 5 * v + Q_140 - u + cur);
				diff = ((gain_q * v) >>> 16) - u;
				udot = sat_q((rate_q * diff) >>> 16);
				vn   = sat_q(v + ((dt_q * vdot) >>> 16));
				u    = sat_q(u + ((dt_q * udot) >>> 16));
				// The peak is also a ceiling for the new potential.
				v = (vn >= peak_q) ? peak_q : vn;
			end
		end
		potential_model[n] = int'(v);
		recovery_model[n]  = int'(u);
		r.new_potential = v[31:0];
		r.new_recovery  = u[31:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		$display("%0t ns: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// Driver. An item is taken at an edge where start is high and busy is low; its expected
	// state is worked out right there, against the registers in force at that moment. A new
	// item is put up, or start is dropped, only once the previous one is gone, so start gets a
	// single assignment per edge and never blinks between two back-to-back items.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (start) begin
				owed_states.push_back(izh_update(request));
			end
			if (queued_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
				request <= queued_requests.pop_front();
				start   <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor. The block cannot be held off, so every strobe is a result to check at once.
	always @(posedge clk) begin
		snpu_out_t want;
		if (arst_n && done) begin
			if (owed_states.size() == 0) begin
				flag_mismatch("unexpected result for neuron", -1, result.neuron_out);
			end else begin
				want = owed_states.pop_front();
				if (result.neuron_out !== want.neuron_out) begin
					flag_mismatch("neuron_out", want.neuron_out, result.neuron_out);
				end
				if (result.new_potential !== want.new_potential) begin
					flag_mismatch($sformatf("new_potential of neuron %0d", want.neuron_out),
						$signed(want.new_potential), $signed(result.new_potential));
				end
				if (result.new_recovery !== want.new_recovery) begin
					flag_mismatch($sformatf("new_recovery of neuron %0d", want.neuron_out),
						$signed(want.new_recovery), $signed(result.new_recovery));
				end
				if (result.spike !== want.spike) begin
					flag_mismatch($sformatf("spike of neuron %0d", want.neuron_out),
						want.spike, result.spike);
				end
			end
		end
	end

	// Queues one item and remembers which neurons have been reset.
	task automatic queue_item(input logic cmd, input int unsigned n, input logic [31:0] cur);
		snpu_in_t it;
		it.cmd          = cmd;
		it.neuron_index = n[IDX_W-1:0];
		it.current      = cur;
		queued_requests.push_back(it);
		if (cmd == CMD_RESET && !live[n]) begin
			live[n] = 1'b1;
			live_ids.push_back(n);
		end
	endtask

	// Mostly currents of a plausible size so that neurons charge up and fire, with some
	// full-range values and the two extremes to push the arithmetic into saturation.
	function automatic logic [31:0] rand_current();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			return 32'(int'($urandom_range(50 * 65536)) - 10 * 65536);
		end else if (sel < 90) begin
			return $urandom;
		end else if (sel < 95) begin
			return 32'h7FFF_FFFF;
		end
		return 32'h8000_0000;
	endfunction

	// Random traffic: mostly runs of steps on a small pool of neurons, so their trajectories go
	// deep through charge, clamp and spike, and now and then a reset anywhere in the population.
	// A neuron that has not been reset yet gets its reset item in place of a step.
	task automatic queue_random(input int count);
		int          k, pick;
		int unsigned n;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				queue_item(CMD_RESET, $urandom_range(NEURONS - 1), $urandom);
			end else if (pick < 14) begin
				queue_item(CMD_RESET, pool[$urandom_range(POOL - 1)], $urandom);
			end else begin
				if (pick < 80) begin
					n = pool[$urandom_range(POOL - 1)];
				end else begin
					n = live_ids[$urandom_range(live_ids.size() - 1)];
				end
				queue_item(live[n] ? CMD_STEP : CMD_RESET, n, rand_current());
			end
		end
	endtask

	// Returns once every queued item has been taken and every result has come back.
	task automatic wait_drained();
		while (queued_requests.size() != 0 || start || owed_states.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input longint value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		case (idx)
			REG_STEP_SIZE:       dt_q      = value[16:0];
			REG_RECOVERY_RATE:   rate_q    = value[16:0];
			REG_RECOVERY_GAIN:   gain_q    = $signed(value[17:0]);
			REG_RESET_POTENTIAL: reset_v_q = $signed(value[23:0]);
			REG_RECOVERY_JUMP:   jump_q    = $signed(value[23:0]);
			REG_PEAK_POTENTIAL:  peak_q    = $signed(value[23:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic apply_settings(input longint dt, input longint a, input longint b,
			input longint c, input longint d, input longint peak);
		write_register(REG_STEP_SIZE, dt);
		write_register(REG_RECOVERY_RATE, a);
		write_register(REG_RECOVERY_GAIN, b);
		write_register(REG_RESET_POTENTIAL, c);
		write_register(REG_RECOVERY_JUMP, d);
		write_register(REG_PEAK_POTENTIAL, peak);
	endtask

	function automatic longint rand_voltage();
		return longint'($urandom_range(13107200)) - 6553600;
	endfunction

	initial begin
		int p, k;
		pool[0] = 0;
		pool[1] = NEURONS - 1;
		for (k = 2; k < POOL; k++) begin
			pool[k] = $urandom_range(NEURONS - 1);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the register values after reset. Neurons 0 and 1023 cover the ends
		// of the index. Neuron 1023 is driven to the peak by the largest current, so the next
		// step fires, the one after that restarts from c, and a reset follows the spike.
		// Neuron 1 takes the most negative current, which saturates v' low and then, with v
		// far below zero, saturates v' high through the square term.
		gap_pct = 29;
		queue_item(CMD_RESET, 0, 32'h0);
		queue_item(CMD_RESET, NEURONS - 1, 32'hFFFF_FFFF);
		queue_item(CMD_RESET, 1, 32'h0);
		queue_item(CMD_RESET, 2, 32'h0);
		queue_item(CMD_RESET, 3, 32'h0);
		queue_item(CMD_STEP, 0, 32'h0);
		queue_item(CMD_STEP, NEURONS - 1, 32'h7FFF_FFFF);
		queue_item(CMD_STEP, NEURONS - 1, 32'h0);
		queue_item(CMD_STEP, NEURONS - 1, 32'h0);
		queue_item(CMD_STEP, 1, 32'h8000_0000);
		queue_item(CMD_STEP, 1, 32'h0);
		queue_item(CMD_STEP, 1, 32'hFFFF_FFFF);
		queue_item(CMD_STEP, 2, 32'(10 * 65536));
		queue_item(CMD_STEP, 2, 32'(10 * 65536));
		queue_item(CMD_STEP, 3, 32'h5555_5555);
		queue_item(CMD_STEP, 3, 32'hAAAA_AAAA);
		queue_item(CMD_RESET, NEURONS - 1, 32'h0);
		queue_item(CMD_STEP, NEURONS - 1, 32'h1);
		queue_item(CMD_STEP, 0, 32'h0);

		// Random part in six settings. The sender holds an item back with a chance of 29 percent for
		// the first two, 45 percent for the next two, and never for the last two. Registers only change
		// once the block has handed back everything it owes.
		for (p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				0: apply_settings(RST_STEP_SIZE, RST_RECOVERY_RATE, RST_RECOVERY_GAIN,
					RST_RESET_POTENTIAL, RST_RECOVERY_JUMP, RST_PEAK_POTENTIAL);
				1: apply_settings(65536, 65536, 65536, 6553600, 6553600, 6553600);
				// A zero time step: v and u stand still but for spikes and resets.
				2: apply_settings(0, 0, -65536, -6553600, -6553600, 6553600);
				4: apply_settings(1, 1, 65536, -6553600, 6553600, -6553600);
				default: apply_settings($urandom_range(1, 65536), $urandom_range(65536),
					longint'($urandom_range(131072)) - 65536, rand_voltage(),
					rand_voltage(), rand_voltage());
			endcase
			gap_pct = (p < 2) ? 29 : (p < 4) ? 45 : 0;
			queue_random(150);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && owed_states.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, where every item waits out the per-neuron
	// spacing and the longest sender gaps.
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
